// ===== rtl/hgsc_pkg.sv =====
// Shared constants, codes and types of the hex-grid site coverage gain block.
`timescale 1ns / 1ps
package hgsc_pkg;

	localparam int MaxRows = 64;
	localparam int MaxCols = 64;
	localparam int RowW    = $clog2(MaxRows);
	localparam int ColW    = $clog2(MaxCols);
	localparam int CellW   = RowW + ColW;
	localparam int Cells   = MaxRows * MaxCols;
	localparam int CntW    = CellW + 1;
	localparam int DimW    = 7;
	localparam int DistW   = 8;
	localparam int GainW   = 13;
	localparam int CmdW    = 2;
	localparam int CfgIdxW = 1;
	localparam int NbW     = 3;

	localparam logic [DistW-1:0] Unreached = 8'hFF;
	localparam logic [DistW-1:0] MaxDist   = 8'hFE;

	localparam logic [CmdW-1:0] CmdClear = 2'd0;
	localparam logic [CmdW-1:0] CmdAdd   = 2'd1;
	localparam logic [CmdW-1:0] CmdEval  = 2'd2;
	localparam logic [CmdW-1:0] CmdNop   = 2'd3;

	localparam logic [CfgIdxW-1:0] CfgRows = 1'b0;
	localparam logic [CfgIdxW-1:0] CfgCols = 1'b1;

	localparam logic [NbW-1:0] NbLast = 3'd5;

	// one spread queue entry: map location, value written, value it replaced
	typedef struct packed {
		logic [CellW-1:0] loc;
		logic [DistW-1:0] newv;
		logic [DistW-1:0] oldv;
	} hgsc_qent_t;

	typedef struct packed {
		logic latch;
		logic clr_step;
		logic best_clr;
		logic src_rd;
		logic src_seed;
		logic q_rd;
		logic q_load;
		logic nb_rd;
		logic nb_upd;
		logic nb_next;
		logic rs_init;
		logic rs_wr;
		logic fin;
	} hgsc_cmd_t;

	typedef struct packed {
		logic [CmdW-1:0] cmd;
		logic            coord_bad;
		logic            src_zero;
		logic            sweep_last;
		logic            q_empty;
		logic            nb_ok;
		logic            nb_last;
	} hgsc_sts_t;

endpackage

// ===== rtl/hex_grid_site_coverage_gain.sv =====
// Top level of the hex-grid site coverage gain block.
`timescale 1ns / 1ps
// One request at a time: start is taken when busy is low, and its result appears
// later on gained_cells, best_gain and coord_error for one cycle with done high;
// the receiver cannot stall it, so capture it then. Clear sweeps one map cell per
// cycle over all 4096 cells. Add and evaluate spread breadth-first from the site
// through a queue, one map read per in-bound neighbour, and evaluate then puts
// the map back. A bad coordinate or command 3 finishes without touching the map.
// After reset the block stays busy while it marks every cell unreached;
// configuration writes are taken throughout.
module hex_grid_site_coverage_gain (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hgsc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [hgsc_pkg::DimW-1:0]     cfg_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic [hgsc_pkg::CmdW-1:0]     command,
	input  logic [hgsc_pkg::RowW-1:0]     row,
	input  logic [hgsc_pkg::ColW-1:0]     col,
	output logic                          done,
	output logic [hgsc_pkg::GainW-1:0]    gained_cells,
	output logic [hgsc_pkg::GainW-1:0]    best_gain,
	output logic                          coord_error
);
	import hgsc_pkg::*;

	hgsc_cmd_t ctl;
	hgsc_sts_t sts;

	hgsc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	hgsc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.command      (command),
		.row          (row),
		.col          (col),
		.ctl          (ctl),
		.sts          (sts),
		.done         (done),
		.gained_cells (gained_cells),
		.best_gain    (best_gain),
		.coord_error  (coord_error)
	);

endmodule

// ===== rtl/hgsc_dp.sv =====
// Datapath: distance map, spread queue, neighbour generation, counters and result registers.
`timescale 1ns / 1ps
module hgsc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hgsc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [hgsc_pkg::DimW-1:0]     cfg_wdata,
	input  logic [hgsc_pkg::CmdW-1:0]     command,
	input  logic [hgsc_pkg::RowW-1:0]     row,
	input  logic [hgsc_pkg::ColW-1:0]     col,
	input  hgsc_pkg::hgsc_cmd_t           ctl,
	output hgsc_pkg::hgsc_sts_t           sts,
	output logic                          done,
	output logic [hgsc_pkg::GainW-1:0]    gained_cells,
	output logic [hgsc_pkg::GainW-1:0]    best_gain,
	output logic                          coord_error
);
	import hgsc_pkg::*;

	logic [DimW-1:0]  rows_q, cols_q, nr, nc;
	logic [CmdW-1:0]  cmd_q;
	logic [RowW-1:0]  row_q;
	logic [ColW-1:0]  col_q;
	logic [CellW-1:0] sweep_q;
	logic [CntW-1:0]  head_q, tail_q;
	logic [NbW-1:0]   k_q;
	logic [CellW-1:0] cur_cell_q;
	logic [DistW-1:0] cur_val_q;
	logic [GainW-1:0] best_q, best_n, gain_n, gain_q, bestout_q;
	logic             done_q, err_q, err_n;

	logic [DistW-1:0] map_mem [Cells];
	logic [DistW-1:0] map_rd_q;
	hgsc_qent_t       q_mem [Cells];
	hgsc_qent_t       q_rd_q;

	logic             coord_bad, upd, odd;
	logic [DimW-1:0]  r7, c7, rr, cc;
	logic [CellW-1:0] src_cell, nb_cell;
	logic [DistW-1:0] nd;
	logic             map_we, map_re, q_we;
	logic [CellW-1:0] map_wa, map_ra;
	logic [DistW-1:0] map_wd;
	hgsc_qent_t       q_wd;

	assign nr = (rows_q == '0) ? DimW'(1) :
		(rows_q > DimW'(MaxRows)) ? DimW'(MaxRows) : rows_q;
	assign nc = (cols_q == '0) ? DimW'(1) :
		(cols_q > DimW'(MaxCols)) ? DimW'(MaxCols) : cols_q;

	assign coord_bad = (DimW'(row_q) >= nr) || (DimW'(col_q) >= nc);
	assign src_cell  = {row_q, col_q};

	// hex neighbours; even columns lean to lower rows, odd to higher
	assign r7  = DimW'(cur_cell_q[CellW-1:ColW]);
	assign c7  = DimW'(cur_cell_q[ColW-1:0]);
	assign odd = cur_cell_q[0];

	always_comb begin
		rr = r7;
		cc = c7;
		case (k_q)
			3'd0: begin
				rr = r7 - DimW'(1);
			end
			3'd1: begin
				rr = r7 + DimW'(1);
			end
			3'd2: begin
				cc = c7 - DimW'(1);
				rr = odd ? r7 : r7 - DimW'(1);
			end
			3'd3: begin
				cc = c7 - DimW'(1);
				rr = odd ? r7 + DimW'(1) : r7;
			end
			3'd4: begin
				cc = c7 + DimW'(1);
				rr = odd ? r7 : r7 - DimW'(1);
			end
			3'd5: begin
				cc = c7 + DimW'(1);
				rr = odd ? r7 + DimW'(1) : r7;
			end
			default: begin
				rr = r7;
				cc = c7;
			end
		endcase
	end

	// a step below zero wraps to all ones and fails the bound check
	assign nb_cell = {rr[RowW-1:0], cc[ColW-1:0]};
	assign nd      = (cur_val_q >= MaxDist) ? MaxDist : cur_val_q + DistW'(1);
	assign upd     = nd < map_rd_q;

	always_comb begin
		map_we = ctl.clr_step | ctl.src_seed | (ctl.nb_upd & upd) | ctl.rs_wr;
		map_wa = sweep_q;
		map_wd = Unreached;
		if (ctl.src_seed) begin
			map_wa = src_cell;
			map_wd = '0;
		end else if (ctl.nb_upd) begin
			map_wa = nb_cell;
			map_wd = nd;
		end else if (ctl.rs_wr) begin
			map_wa = q_rd_q.loc;
			map_wd = q_rd_q.oldv;
		end
		map_re = ctl.src_rd | ctl.nb_rd;
		map_ra = ctl.src_rd ? src_cell : nb_cell;
	end

	always_comb begin
		q_we = ctl.src_seed | (ctl.nb_upd & upd);
		if (ctl.src_seed) begin
			q_wd = '{loc: src_cell, newv: '0, oldv: map_rd_q};
		end else begin
			q_wd = '{loc: nb_cell, newv: nd, oldv: map_rd_q};
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (map_re) begin
			map_rd_q <= map_mem[map_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[tail_q[CellW-1:0]] <= q_wd;
		end
		if (ctl.q_rd) begin
			q_rd_q <= q_mem[head_q[CellW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= command;
			row_q <= row;
			col_q <= col;
		end
		if (ctl.q_load) begin
			cur_cell_q <= q_rd_q.loc;
			cur_val_q  <= q_rd_q.newv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DimW'(MaxRows);
			cols_q <= DimW'(MaxCols);
		end else if (cfg_we) begin
			if (cfg_index == CfgRows) begin
				rows_q <= cfg_wdata;
			end
			if (cfg_index == CfgCols) begin
				cols_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			k_q     <= '0;
		end else begin
			if (ctl.latch) begin
				sweep_q <= '0;
				head_q  <= '0;
				tail_q  <= '0;
			end
			if (ctl.clr_step) begin
				sweep_q <= sweep_q + CellW'(1);
			end
			if (ctl.rs_init) begin
				head_q <= '0;
			end else if (ctl.q_rd) begin
				head_q <= head_q + CntW'(1);
			end
			if (q_we) begin
				tail_q <= tail_q + CntW'(1);
			end
			if (ctl.q_load) begin
				k_q <= '0;
			end else if (ctl.nb_next) begin
				k_q <= k_q + NbW'(1);
			end
		end
	end

	// every changed cell went through the queue exactly once
	assign gain_n = (cmd_q == CmdEval && !coord_bad) ? GainW'(tail_q) : '0;
	assign best_n = (gain_n > best_q) ? gain_n : best_q;
	assign err_n  = coord_bad && (cmd_q == CmdAdd || cmd_q == CmdEval);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.fin;
			if (ctl.best_clr) begin
				best_q <= '0;
			end else if (ctl.fin) begin
				best_q <= best_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			gain_q    <= gain_n;
			bestout_q <= best_n;
			err_q     <= err_n;
		end
	end

	assign sts = '{
		cmd:        cmd_q,
		coord_bad:  coord_bad,
		src_zero:   map_rd_q == '0,
		sweep_last: &sweep_q,
		q_empty:    head_q == tail_q,
		nb_ok:      (rr < nr) && (cc < nc),
		nb_last:    k_q == NbLast
	};

	assign done         = done_q;
	assign gained_cells = gain_q;
	assign best_gain    = bestout_q;
	assign coord_error  = err_q;

endmodule

// ===== rtl/hgsc_ctrl.sv =====
// Controller state machine sequencing clear sweeps, spreads and restore passes.
`timescale 1ns / 1ps
module hgsc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  hgsc_pkg::hgsc_sts_t  sts,
	output hgsc_pkg::hgsc_cmd_t  ctl
);
	import hgsc_pkg::*;

	localparam logic [3:0] S_INIT = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DISP = 4'd2;
	localparam logic [3:0] S_CLR  = 4'd3;
	localparam logic [3:0] S_SRC  = 4'd4;
	localparam logic [3:0] S_QRD  = 4'd5;
	localparam logic [3:0] S_QLD  = 4'd6;
	localparam logic [3:0] S_NRD  = 4'd7;
	localparam logic [3:0] S_NCMP = 4'd8;
	localparam logic [3:0] S_RSRD = 4'd9;
	localparam logic [3:0] S_RSWR = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	logic [3:0] state_q, state_d;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				ctl.clr_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.cmd) inside
					CmdClear: begin
						ctl.best_clr = 1'b1;
						state_d      = S_CLR;
					end
					CmdAdd, CmdEval: begin
						if (sts.coord_bad) begin
							state_d = S_FIN;
						end else begin
							ctl.src_rd = 1'b1;
							state_d    = S_SRC;
						end
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_CLR: begin
				ctl.clr_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_FIN;
				end
			end
			S_SRC: begin
				if (sts.src_zero) begin
					state_d = S_FIN;
				end else begin
					ctl.src_seed = 1'b1;
					state_d      = S_QRD;
				end
			end
			S_QRD: begin
				if (!sts.q_empty) begin
					ctl.q_rd = 1'b1;
					state_d  = S_QLD;
				end else if (sts.cmd == CmdEval) begin
					ctl.rs_init = 1'b1;
					state_d     = S_RSRD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_QLD: begin
				ctl.q_load = 1'b1;
				state_d    = S_NRD;
			end
			S_NRD: begin
				if (sts.nb_ok) begin
					ctl.nb_rd = 1'b1;
					state_d   = S_NCMP;
				end else if (sts.nb_last) begin
					state_d = S_QRD;
				end else begin
					ctl.nb_next = 1'b1;
				end
			end
			S_NCMP: begin
				ctl.nb_upd = 1'b1;
				if (sts.nb_last) begin
					state_d = S_QRD;
				end else begin
					ctl.nb_next = 1'b1;
					state_d     = S_NRD;
				end
			end
			S_RSRD: begin
				if (sts.q_empty) begin
					state_d = S_FIN;
				end else begin
					ctl.q_rd = 1'b1;
					state_d  = S_RSWR;
				end
			end
			S_RSWR: begin
				ctl.rs_wr = 1'b1;
				state_d   = S_RSRD;
			end
			S_FIN: begin
				ctl.fin = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

// ===== rtl/hgsc_chk.sv =====
// Port-level assertion checker for the hex-grid site coverage gain block, with its bind.
`timescale 1ns / 1ps
module hgsc_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [hgsc_pkg::GainW-1:0]    gained_cells,
	input logic [hgsc_pkg::GainW-1:0]    best_gain,
	input logic                          coord_error
);
	import hgsc_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but block not busy");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	a_err_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(done && coord_error) |-> (gained_cells == '0))
		else $error("gain reported for a bad coordinate");

	a_best: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (gained_cells <= best_gain))
		else $error("best gain below current gain");

endmodule

bind hex_grid_site_coverage_gain hgsc_chk u_hgsc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.gained_cells (gained_cells),
	.best_gain    (best_gain),
	.coord_error  (coord_error)
);
